[rtl/ctc_pkg.sv]
package ctc_pkg;

	localparam int LINE_COLUMNS = 4096;
	localparam int COL_W = 12;
	localparam int LEN_W = 13;

	// positions saturate here; word lengths saturate one above
	localparam logic [LEN_W-1:0] COL_MAX =
		LEN_W'((LINE_COLUMNS - 1 < 4095) ? LINE_COLUMNS - 1 : 4095);
	localparam logic [LEN_W-1:0] LEN_MAX =
		LEN_W'((LINE_COLUMNS < 4096) ? LINE_COLUMNS : 4096);

	localparam logic [1:0] OPC_CHAR = 2'd0;
	localparam logic [1:0] OPC_EOL  = 2'd1;
	localparam logic [1:0] OPC_EOT  = 2'd2;

	localparam logic [2:0] CLS_KEY   = 3'd0;
	localparam logic [2:0] CLS_NUM   = 3'd1;
	localparam logic [2:0] CLS_OP    = 3'd2;
	localparam logic [2:0] CLS_IDENT = 3'd3;
	localparam logic [2:0] CLS_END   = 3'd4;

	localparam logic [1:0] KW_NONE = 2'd0;

	localparam int QDEPTH = 4;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [2:0]       token_class;
		logic [1:0]       keyword_id;
		logic [7:0]       first_char;
		logic [7:0]       second_char;
		logic [COL_W-1:0] start_col;
		logic [LEN_W-1:0] token_length;
		logic             col_overflow;
		logic             last_of_run;
	} tok_t;

	// up to two tokens produced by one input word
	typedef struct packed {
		logic [1:0] n;
		tok_t       r0;
		tok_t       r1;
	} push_t;

endpackage

[rtl/ctc_char_if.sv]
interface ctc_char_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] char_code;

	modport source (output valid, output opcode, output char_code, input ready);
	modport sink (input valid, input opcode, input char_code, output ready);
endinterface

[rtl/ctc_token_if.sv]
interface ctc_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_class;
	logic [1:0]  keyword_id;
	logic [7:0]  first_char;
	logic [7:0]  second_char;
	logic [11:0] start_col;
	logic [12:0] token_length;
	logic        col_overflow;
	logic        last_of_run;

	modport source (output valid, output token_class, output keyword_id,
		output first_char, output second_char, output start_col,
		output token_length, output col_overflow, output last_of_run,
		input ready);
	modport sink (input valid, input token_class, input keyword_id,
		input first_char, input second_char, input start_col,
		input token_length, input col_overflow, input last_of_run,
		output ready);
endinterface

[rtl/ctc_core.sv]
module ctc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     in_opcode,
	input  logic [7:0]     in_char,
	input  logic           room,
	output ctc_pkg::push_t push
);
	import ctc_pkg::*;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" ||
			c == "}" || c == ";";
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == "+" || c == "-" || c == "/" || c == "*" || c == "<" ||
			c == ">" || c == "~" || c == "!" || c == "|" || c == "&" || c == "=";
	endfunction

	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
		return (a == b && (a == "+" || a == "-" || a == "|" || a == "&" ||
			a == "=")) || (b == "=" && (a == ">" || a == "<" || a == "!"));
	endfunction

	function automatic logic [LEN_W-1:0] kw_len(input logic [1:0] i);
		case (i)
			2'd0: return LEN_W'(3);
			2'd1: return LEN_W'(6);
			2'd2: return LEN_W'(5);
			default: return '0;
		endcase
	endfunction

	// character idx of keyword i: 0 int, 1 return, 2 float
	function automatic logic [7:0] kw_char(input logic [1:0] i, input logic [2:0] idx);
		logic [7:0] r;
		r = 8'd0;
		case (i)
			2'd0: begin
				case (idx)
					3'd0: r = "i";
					3'd1: r = "n";
					3'd2: r = "t";
					default: r = 8'd0;
				endcase
			end
			2'd1: begin
				case (idx)
					3'd0: r = "r";
					3'd1: r = "e";
					3'd2: r = "t";
					3'd3: r = "u";
					3'd4: r = "r";
					3'd5: r = "n";
					default: r = 8'd0;
				endcase
			end
			2'd2: begin
				case (idx)
					3'd0: r = "f";
					3'd1: r = "l";
					3'd2: r = "o";
					3'd3: r = "a";
					3'd4: r = "t";
					default: r = 8'd0;
				endcase
			end
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// input register
	logic       v_s1;
	logic [1:0] opc_s1;
	logic [7:0] chr_s1;
	logic       adv;

	assign adv = v_s1 && room;
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opc_s1 <= in_opcode;
			chr_s1 <= in_char;
		end
	end

	// lexer state
	logic             in_word_q, all_digits_q, op_pending_q, ovf_q;
	logic [LEN_W-1:0] word_len_q, column_q;
	logic [COL_W-1:0] word_start_q, pending_col_q;
	logic [7:0]       word_first_q, pending_char_q;
	logic [2:0]       kc_q;

	logic             in_word_d, all_digits_d, op_pending_d, ovf_d;
	logic [LEN_W-1:0] word_len_d, column_d;
	logic [COL_W-1:0] word_start_d, pending_col_d;
	logic [7:0]       word_first_d, pending_char_d;
	logic [2:0]       kc_d;

	logic             col_sat, ovf_now, fl_valid;
	logic [COL_W-1:0] pos;
	logic [1:0]       kid;
	tok_t             fl_tok, new_tok;
	logic [LEN_W-1:0] wl;
	logic [2:0]       kc;
	logic             ad;

	always_comb begin
		col_sat = column_q > COL_MAX;
		pos     = col_sat ? COL_MAX[COL_W-1:0] : column_q[COL_W-1:0];
		ovf_now = ovf_q || col_sat;

		kid = KW_NONE;
		for (int i = 0; i < 3; i++) begin
			if (kc_q[i] && word_len_q == kw_len(2'(i)))
				kid = 2'(i + 1);
		end

		// token that a flush would emit; col_overflow filled in per path
		fl_valid = in_word_q || op_pending_q;
		fl_tok   = '0;
		if (in_word_q) begin
			fl_tok.token_class  = (kid != KW_NONE) ? CLS_KEY :
				(all_digits_q ? CLS_NUM : CLS_IDENT);
			fl_tok.keyword_id   = kid;
			fl_tok.first_char   = word_first_q;
			fl_tok.start_col    = word_start_q;
			fl_tok.token_length = word_len_q;
		end else begin
			fl_tok.token_class  = CLS_OP;
			fl_tok.first_char   = pending_char_q;
			fl_tok.start_col    = pending_col_q;
			fl_tok.token_length = LEN_W'(1);
		end

		in_word_d      = in_word_q;
		all_digits_d   = all_digits_q;
		op_pending_d   = op_pending_q;
		ovf_d          = ovf_q;
		word_len_d     = word_len_q;
		column_d       = column_q;
		word_start_d   = word_start_q;
		pending_col_d  = pending_col_q;
		word_first_d   = word_first_q;
		pending_char_d = pending_char_q;
		kc_d           = kc_q;

		push    = '0;
		new_tok = '0;
		wl      = '0;
		kc      = '0;
		ad      = 1'b0;

		if (opc_s1 == OPC_EOL || opc_s1 == OPC_EOT) begin
			if (fl_valid) begin
				push.r0 = fl_tok;
				push.r0.col_overflow = ovf_q;
				push.n = 2'd1;
			end
			in_word_d      = 1'b0;
			word_len_d     = '0;
			all_digits_d   = 1'b1;
			kc_d           = 3'b111;
			op_pending_d   = 1'b0;
			pending_char_d = 8'd0;
			column_d       = '0;
			ovf_d          = 1'b0;
			if (opc_s1 == OPC_EOT) begin
				new_tok.token_class = CLS_END;
				if (fl_valid)
					push.r1 = new_tok;
				else
					push.r0 = new_tok;
				push.n = push.n + 2'd1;
				word_start_d  = '0;
				word_first_d  = 8'd0;
				pending_col_d = '0;
			end
		end else if (opc_s1 == OPC_CHAR) begin
			ovf_d    = ovf_now;
			column_d = col_sat ? column_q : column_q + LEN_W'(1);
			fl_tok.col_overflow = ovf_now;
			if (is_space(chr_s1)) begin
				push.n = 2'd0;
			end else if (is_punct(chr_s1)) begin
				new_tok.token_class  = CLS_KEY;
				new_tok.first_char   = chr_s1;
				new_tok.start_col    = pos;
				new_tok.token_length = LEN_W'(1);
				new_tok.col_overflow = ovf_now;
				if (fl_valid) begin
					push.r0 = fl_tok;
					push.r1 = new_tok;
					push.n  = 2'd2;
				end else begin
					push.r0 = new_tok;
					push.n  = 2'd1;
				end
				in_word_d      = 1'b0;
				word_len_d     = '0;
				all_digits_d   = 1'b1;
				kc_d           = 3'b111;
				op_pending_d   = 1'b0;
				pending_char_d = 8'd0;
			end else if (is_op(chr_s1)) begin
				if (op_pending_q && is_pair(pending_char_q, chr_s1)) begin
					push.r0.token_class  = CLS_OP;
					push.r0.first_char   = pending_char_q;
					push.r0.second_char  = chr_s1;
					push.r0.start_col    = pending_col_q;
					push.r0.token_length = LEN_W'(2);
					push.r0.col_overflow = ovf_now;
					push.n = 2'd1;
					op_pending_d   = 1'b0;
					pending_char_d = 8'd0;
				end else begin
					if (fl_valid) begin
						push.r0 = fl_tok;
						push.n  = 2'd1;
					end
					in_word_d      = 1'b0;
					word_len_d     = '0;
					all_digits_d   = 1'b1;
					kc_d           = 3'b111;
					op_pending_d   = 1'b1;
					pending_char_d = chr_s1;
					pending_col_d  = pos;
				end
			end else begin
				// word character; a new word flushes a pending operator
				wl = word_len_q;
				kc = kc_q;
				ad = all_digits_q;
				if (!in_word_q) begin
					if (op_pending_q) begin
						push.r0 = fl_tok;
						push.n  = 2'd1;
					end
					op_pending_d   = 1'b0;
					pending_char_d = 8'd0;
					wl = '0;
					kc = 3'b111;
					ad = 1'b1;
					word_start_d = pos;
					word_first_d = chr_s1;
				end
				in_word_d = 1'b1;
				if (chr_s1 < "0" || chr_s1 > "9")
					ad = 1'b0;
				for (int i = 0; i < 3; i++) begin
					if (wl >= kw_len(2'(i)) || kw_char(2'(i), wl[2:0]) != chr_s1)
						kc[i] = 1'b0;
				end
				all_digits_d = ad;
				kc_d         = kc;
				if (wl < LEN_MAX)
					word_len_d = wl + LEN_W'(1);
				else begin
					word_len_d = wl;
					ovf_d      = 1'b1;
				end
			end
		end

		if (push.n == 2'd2)
			push.r1.last_of_run = 1'b1;
		else if (push.n == 2'd1)
			push.r0.last_of_run = 1'b1;

		if (!adv)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q      <= 1'b0;
			all_digits_q   <= 1'b1;
			op_pending_q   <= 1'b0;
			ovf_q          <= 1'b0;
			word_len_q     <= '0;
			column_q       <= '0;
			word_start_q   <= '0;
			pending_col_q  <= '0;
			word_first_q   <= 8'd0;
			pending_char_q <= 8'd0;
			kc_q           <= 3'b111;
		end else if (adv) begin
			in_word_q      <= in_word_d;
			all_digits_q   <= all_digits_d;
			op_pending_q   <= op_pending_d;
			ovf_q          <= ovf_d;
			word_len_q     <= word_len_d;
			column_q       <= column_d;
			word_start_q   <= word_start_d;
			pending_col_q  <= pending_col_d;
			word_first_q   <= word_first_d;
			pending_char_q <= pending_char_d;
			kc_q           <= kc_d;
		end
	end

`ifndef SYNTH
	a_word_op_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_word_q && op_pending_q))
		else $error("word and pending operator both open");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2 && push.r1.token_class == CLS_END) |->
		(push.r1.last_of_run && push.r1.start_col == '0 && push.r1.first_char == 8'd0))
		else $error("end-of-text token malformed");

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && opc_s1 == OPC_EOT) |=>
		(!in_word_q && !op_pending_q && column_q == '0 && kc_q == 3'b111))
		else $error("state not cleared after end of text");
`endif

endmodule

[rtl/ctc_fifo.sv]
module ctc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  ctc_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output ctc_pkg::tok_t  head
);
	import ctc_pkg::*;

	// shift queue: entry 0 is the head
	tok_t              ent_q [QDEPTH];
	tok_t              ent_d [QDEPTH];
	logic [QCNT_W-1:0] cnt_q, cnt_d, base;
	logic              pop;

	assign room      = cnt_q <= QCNT_W'(QDEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign head      = ent_q[0];
	assign pop       = out_valid && out_ready;

	always_comb begin
		base = cnt_q - QCNT_W'(pop);
		for (int i = 0; i < QDEPTH; i++) begin
			if (pop && i < QDEPTH - 1)
				ent_d[i] = ent_q[i + 1];
			else
				ent_d[i] = ent_q[i];
			if (push.n != 2'd0 && base == QCNT_W'(i))
				ent_d[i] = push.r0;
			if (push.n == 2'd2 && base + QCNT_W'(1) == QCNT_W'(i))
				ent_d[i] = push.r1;
		end
		cnt_d = base + QCNT_W'(push.n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++)
			ent_q[i] <= ent_d[i];
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("push without room");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.n == 2'd0) |=> cnt_q == $past(cnt_q) - QCNT_W'(1))
		else $error("queue count lost a word");
`endif

endmodule

[rtl/c_subset_token_classifier.sv]
// An accepted word passes the input register before its tokens enter the result queue.
// Throughput: one input word per cycle while at most one token per word is produced and the
//   result queue has room for two tokens; a word that yields two tokens needs two transfers
//   on the single output port, which drains the 4-entry result queue.
// Reset: arst_n asynchronous, active low; clears lexer state and empties the queue.
module c_subset_token_classifier (
	input  logic        clk,
	input  logic        arst_n,
	ctc_char_if.sink    chars,
	ctc_token_if.source tokens
);
	import ctc_pkg::*;

	push_t push;
	logic  room;
	tok_t  head;

	ctc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_ready  (chars.ready),
		.in_opcode (chars.opcode),
		.in_char   (chars.char_code),
		.room      (room),
		.push      (push)
	);

	ctc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (tokens.valid),
		.out_ready (tokens.ready),
		.head      (head)
	);

	assign tokens.token_class  = head.token_class;
	assign tokens.keyword_id   = head.keyword_id;
	assign tokens.first_char   = head.first_char;
	assign tokens.second_char  = head.second_char;
	assign tokens.start_col    = head.start_col;
	assign tokens.token_length = head.token_length;
	assign tokens.col_overflow = head.col_overflow;
	assign tokens.last_of_run  = head.last_of_run;

endmodule

[dv/tb_c_subset_token_classifier.sv]
module tb_c_subset_token_classifier;
	import ctc_pkg::*;

	// opcode 3 is unused; the block drops the word
	localparam logic [1:0] OPC_NONE = 2'd3;
	localparam logic [1:0] KW_INT = 2'd1;
	localparam logic [1:0] KW_RETURN = 2'd2;
	localparam logic [1:0] KW_FLOAT = 2'd3;

	localparam int STIM_ITEMS = 1250;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [1:0] opc;
		logic [7:0] ch;
		logic [2:0] gap;
		logic       drain;
	} char_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic drv_valid = 1'b0;
	logic [1:0] drv_opc = OPC_CHAR;
	logic [7:0] drv_char = 8'h00;
	logic rx_ready = 1'b0;

	ctc_char_if chars_if ();
	ctc_token_if tok_if ();

	assign chars_if.valid = drv_valid;
	assign chars_if.opcode = drv_opc;
	assign chars_if.char_code = drv_char;
	assign tok_if.ready = rx_ready;

	c_subset_token_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.tokens(tok_if)
	);

	char_item_t pending_q[$];
	tok_t exp_tokens[$];
	tok_t lx_run[$];

	string kw_words [3] = '{"int", "return", "float"};

	int err_cnt = 0;
	int stim_cnt = 0;
	int in_acc_cnt = 0;
	int tx_gap = 0;
	int rx_wait = 0;
	int rx_cnt = 0;
	int hold_left = 0;
	int holds_done = 0;

	// lexer model state
	logic             lx_in_word;
	logic             lx_all_digits;
	logic             lx_op_pend;
	logic             lx_ovf;
	logic [LEN_W-1:0] lx_word_len;
	logic [LEN_W-1:0] lx_column;
	logic [COL_W-1:0] lx_word_start;
	logic [COL_W-1:0] lx_pend_col;
	logic [7:0]       lx_word_first;
	logic [7:0]       lx_pend_char;
	logic [2:0]       lx_kw_cand;

	function automatic logic in_set(input logic [7:0] c, input string s);
		for (int i = 0; i < s.len(); i++)
			if (c == s[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return in_set(c, "()[]{};");
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return in_set(c, "+-/*<>~!|&=");
	endfunction

	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
		return (a == b && in_set(a, "+-|&=")) || (b == "=" && in_set(a, "><!"));
	endfunction

	function automatic logic [1:0] kw_code(input int i);
		case (i)
			0: return KW_INT;
			1: return KW_RETURN;
			default: return KW_FLOAT;
		endcase
	endfunction

	function automatic tok_t mk_tok(input logic [2:0] cls, input logic [1:0] kid,
		input logic [7:0] f, input logic [7:0] s, input logic [COL_W-1:0] col,
		input logic [LEN_W-1:0] len, input logic ovf);
		tok_t t;
		t.token_class = cls;
		t.keyword_id = kid;
		t.first_char = f;
		t.second_char = s;
		t.start_col = col;
		t.token_length = len;
		t.col_overflow = ovf;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	task automatic lx_reset();
		lx_in_word = 1'b0;
		lx_word_len = '0;
		lx_word_start = '0;
		lx_word_first = 8'h00;
		lx_column = '0;
		lx_all_digits = 1'b1;
		lx_kw_cand = 3'b111;
		lx_op_pend = 1'b0;
		lx_pend_char = 8'h00;
		lx_pend_col = '0;
		lx_ovf = 1'b0;
	endtask

	// emit the open word or the held operator, if any
	task automatic close_token();
		logic [2:0] cls;
		logic [1:0] kid;
		if (lx_in_word) begin
			cls = lx_all_digits ? CLS_NUM : CLS_IDENT;
			kid = KW_NONE;
			for (int i = 0; i < 3; i++)
				if (lx_kw_cand[i] && lx_word_len == LEN_W'(kw_words[i].len())) begin
					cls = CLS_KEY;
					kid = kw_code(i);
				end
			lx_run.push_back(mk_tok(cls, kid, lx_word_first, 8'h00, lx_word_start,
				lx_word_len, lx_ovf));
			lx_in_word = 1'b0;
			lx_word_len = '0;
			lx_all_digits = 1'b1;
			lx_kw_cand = 3'b111;
		end else if (lx_op_pend) begin
			lx_run.push_back(mk_tok(CLS_OP, KW_NONE, lx_pend_char, 8'h00, lx_pend_col,
				LEN_W'(1), lx_ovf));
			lx_op_pend = 1'b0;
			lx_pend_char = 8'h00;
		end
	endtask

	task automatic lex_predict(input logic [1:0] opc, input logic [7:0] c);
		logic [COL_W-1:0] pos;
		tok_t t;
		lx_run.delete();
		if (opc == OPC_EOL || opc == OPC_EOT) begin
			close_token();
			lx_column = '0;
			lx_ovf = 1'b0;
			if (opc == OPC_EOT) begin
				lx_run.push_back(mk_tok(CLS_END, KW_NONE, 8'h00, 8'h00, '0, '0, 1'b0));
				lx_reset();
			end
		end else if (opc == OPC_CHAR) begin
			pos = lx_column[COL_W-1:0];
			if (lx_column > COL_MAX) begin
				pos = COL_MAX[COL_W-1:0];
				lx_ovf = 1'b1;
			end
			if (lx_column <= COL_MAX)
				lx_column = lx_column + LEN_W'(1);
			if (is_space(c)) begin
				// only the column moves
			end else if (is_punct(c)) begin
				close_token();
				lx_run.push_back(mk_tok(CLS_KEY, KW_NONE, c, 8'h00, pos, LEN_W'(1), lx_ovf));
			end else if (is_op(c)) begin
				if (lx_op_pend && is_pair(lx_pend_char, c)) begin
					lx_run.push_back(mk_tok(CLS_OP, KW_NONE, lx_pend_char, c, lx_pend_col,
						LEN_W'(2), lx_ovf));
					lx_op_pend = 1'b0;
					lx_pend_char = 8'h00;
				end else begin
					close_token();
					lx_op_pend = 1'b1;
					lx_pend_char = c;
					lx_pend_col = pos;
				end
			end else begin
				if (!lx_in_word) begin
					close_token();
					lx_in_word = 1'b1;
					lx_word_len = '0;
					lx_word_start = pos;
					lx_word_first = c;
					lx_all_digits = 1'b1;
					lx_kw_cand = 3'b111;
				end
				if (c < "0" || c > "9")
					lx_all_digits = 1'b0;
				for (int i = 0; i < 3; i++)
					if (lx_word_len >= LEN_W'(kw_words[i].len()) ||
						kw_words[i][lx_word_len] != c)
						lx_kw_cand[i] = 1'b0;
				if (lx_word_len < LEN_MAX)
					lx_word_len = lx_word_len + LEN_W'(1);
				else
					lx_ovf = 1'b1;
			end
		end
		if (lx_run.size() != 0) begin
			t = lx_run.pop_back();
			t.last_of_run = 1'b1;
			lx_run.push_back(t);
		end
		foreach (lx_run[i])
			exp_tokens.push_back(lx_run[i]);
	endtask

	task automatic log_token_error(input string msg);
		$display("ERROR t=%0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic check_field(input string name, input logic [LEN_W-1:0] got,
		input logic [LEN_W-1:0] want);
		if (got !== want)
			log_token_error($sformatf("token %0d %s: got %0d, want %0d", rx_cnt, name,
				got, want));
	endtask

	task automatic check_token();
		tok_t want;
		if (exp_tokens.size() == 0) begin
			log_token_error($sformatf("unexpected token class %0d first_char %h",
				tok_if.token_class, tok_if.first_char));
			return;
		end
		want = exp_tokens.pop_front();
		check_field("token_class", LEN_W'(tok_if.token_class), LEN_W'(want.token_class));
		check_field("keyword_id", LEN_W'(tok_if.keyword_id), LEN_W'(want.keyword_id));
		check_field("first_char", LEN_W'(tok_if.first_char), LEN_W'(want.first_char));
		check_field("second_char", LEN_W'(tok_if.second_char), LEN_W'(want.second_char));
		check_field("start_col", LEN_W'(tok_if.start_col), LEN_W'(want.start_col));
		check_field("token_length", tok_if.token_length, want.token_length);
		check_field("col_overflow", LEN_W'(tok_if.col_overflow), LEN_W'(want.col_overflow));
		check_field("last_of_run", LEN_W'(tok_if.last_of_run), LEN_W'(want.last_of_run));
	endtask

	// stimulus building
	task automatic put_item(input logic [1:0] opc, input logic [7:0] ch);
		char_item_t it;
		it.opc = opc;
		it.ch = ch;
		it.drain = 1'b0;
		// every third block of 150 words goes without sender gaps
		it.gap = ((pending_q.size() / 150) % 3 == 0) ? 3'd0 : 3'($urandom_range(0, 5));
		pending_q.push_back(it);
		if (opc != OPC_NONE)
			stim_cnt++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_item(OPC_CHAR, s[i]);
	endtask

	task automatic put_drain();
		char_item_t it;
		it.opc = OPC_CHAR;
		it.ch = 8'h00;
		it.gap = 3'd0;
		it.drain = 1'b1;
		pending_q.push_back(it);
	endtask

	function automatic logic [7:0] rand_word_byte();
		logic [7:0] b;
		b = " ";
		while (is_space(b) || is_punct(b) || is_op(b)) begin
			if ($urandom_range(0, 3) != 0)
				b = 8'("a" + $urandom_range(0, 25));
			else
				b = 8'($urandom_range(0, 255));
		end
		return b;
	endfunction

	function automatic logic [7:0] rand_space();
		int n;
		n = $urandom_range(8, 13);
		return (n == 8) ? 8'(" ") : 8'(n);
	endfunction

	task automatic gen_token();
		string ops;
		string puncts;
		string pairs;
		string kw;
		int r;
		int n;
		ops = "+-/*<>~!|&=";
		puncts = "()[]{};";
		pairs = "++--||&&==>=<=!=";
		r = $urandom_range(0, 99);
		if (r < 12) begin
			kw = kw_words[$urandom_range(0, 2)];
			case ($urandom_range(0, 4))
				0: put_text(kw.substr(0, kw.len() - 2));
				1: begin
					put_text(kw);
					put_item(OPC_CHAR, rand_word_byte());
				end
				default: put_text(kw);
			endcase
		end else if (r < 24) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				put_item(OPC_CHAR, 8'("0" + $urandom_range(0, 9)));
		end else if (r < 40) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				put_item(OPC_CHAR, rand_word_byte());
		end else if (r < 52) begin
			put_item(OPC_CHAR, puncts[$urandom_range(0, puncts.len() - 1)]);
		end else if (r < 70) begin
			put_item(OPC_CHAR, ops[$urandom_range(0, ops.len() - 1)]);
		end else if (r < 80) begin
			n = $urandom_range(0, 7);
			put_item(OPC_CHAR, pairs[2 * n]);
			if ($urandom_range(0, 2) == 0)
				put_item(OPC_CHAR, rand_space());
			put_item(OPC_CHAR, pairs[2 * n + 1]);
		end else if (r < 90) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				put_item(OPC_CHAR, rand_space());
		end else if (r < 95) begin
			put_item(OPC_EOL, 8'($urandom_range(0, 255)));
		end else if (r < 96) begin
			put_item(OPC_EOT, 8'($urandom_range(0, 255)));
		end else if (r < 97) begin
			put_item(OPC_NONE, 8'($urandom_range(0, 255)));
		end else begin
			put_item(OPC_CHAR, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 1) == 0)
			put_item(OPC_CHAR, rand_space());
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin : driver
		char_item_t it;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (drv_valid && chars_if.ready) begin
				lex_predict(drv_opc, drv_char);
				in_acc_cnt <= in_acc_cnt + 1;
			end
			if (!drv_valid || chars_if.ready) begin
				if (tx_gap != 0) begin
					drv_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (pending_q.size() != 0 && pending_q[0].drain) begin
					// pause until every token in flight has come out
					drv_valid <= 1'b0;
					if (exp_tokens.size() == 0)
						void'(pending_q.pop_front());
				end else if (pending_q.size() != 0) begin
					it = pending_q.pop_front();
					drv_valid <= 1'b1;
					drv_opc <= it.opc;
					drv_char <= it.ch;
					tx_gap <= int'(it.gap);
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver stalls so the result queue fills and backs up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && in_acc_cnt >= 250) ||
			(holds_done == 1 && in_acc_cnt >= 700)) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin : monitor
		int w;
		if (!arst_n) begin
			rx_ready <= 1'b0;
			rx_wait <= 0;
			rx_cnt <= 0;
		end else begin
			w = rx_wait;
			if (tok_if.valid && rx_ready) begin
				check_token();
				rx_cnt <= rx_cnt + 1;
				w = ((rx_cnt / 64) % 3 == 1) ? 0 : $urandom_range(0, 5);
			end else if (w != 0) begin
				w = w - 1;
			end
			rx_wait <= w;
			rx_ready <= (w == 0) && (hold_left == 0);
		end
	end

	initial begin : stim
		bit drained_a;
		bit drained_b;
		drained_a = 1'b0;
		drained_b = 1'b0;
		lx_reset();

		// keyword, identifier, pair across a blank, word ended by punctuator
		put_text("int a+ +b;");
		// operator followed by punctuator
		put_text("<(");
		// operator at end of line
		put_text("x-");
		put_item(OPC_EOL, 8'h00);
		// byte extremes form one word, closed by end of text
		put_item(OPC_CHAR, 8'h00);
		put_item(OPC_CHAR, 8'hFF);
		put_item(OPC_NONE, 8'hFF);
		put_item(OPC_EOT, 8'hFF);

		while (stim_cnt < STIM_ITEMS) begin
			gen_token();
			if (!drained_a && stim_cnt >= 500) begin
				put_drain();
				drained_a = 1'b1;
			end
			if (!drained_b && stim_cnt >= 1000) begin
				put_drain();
				drained_b = 1'b1;
			end
		end

		put_item(OPC_EOT, 8'h00);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || drv_valid)
			@(posedge clk);
		while (exp_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (exp_tokens.size() != 0)
			log_token_error($sformatf("%0d expected tokens never came", exp_tokens.size()));
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
